// ===== rtl/core/wsd_pkg.sv =====
// Shared constants and codes for the work-stealing deque core.
`default_nettype none

package wsd_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = ADDR_W + 1;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam int IN_TDATA_W  = ((OP_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STATUS_W + DATA_W + 7) / 8) * 8;
    localparam int IN_PAD_W    = IN_TDATA_W - OP_W - DATA_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - DATA_W;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [DATA_W-1:0]   data_t;

    localparam op_t OP_PUSH  = 2'd0;
    localparam op_t OP_TAKE  = 2'd1;
    localparam op_t OP_STEAL = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/wsd_ram.sv =====
// Single-clock RAM with one write port and one registered read port.
`default_nettype none

module wsd_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/work_stealing_deque_core.sv =====
// Top level of the work-stealing deque: pointer control, entry RAM and result register.
`default_nettype none

// Circular task deque of DEPTH words. Each input item is a push at the bottom,
// a take from the bottom or a steal from the top, and gives exactly one result
// item with a status and a task word. On acceptance the pointers update and the
// entry RAM is accessed; the registered RAM read data is then captured into the
// output register once that register is free or its result is being taken. A
// new item is accepted only after the held one has moved to the output register,
// since the block holds one item in flight between the RAM read and the output
// register. A push on a full deque is dropped with status full; a take or steal
// on an empty deque returns status empty and a zero word.
module work_stealing_deque_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata: operation [1:0], push_value [33:2], zero padding above.
    input  wire logic [wsd_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata: status [1:0], item_value [33:2], zero padding above.
    output logic [wsd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    import wsd_pkg::*;

    op_t     in_op;
    data_t   in_value;
    logic    s_fire;
    ptr_t    level;
    logic    is_empty;
    logic    is_full;
    ptr_t    newest;

    ptr_t    top_reg;
    ptr_t    top_next;
    ptr_t    bottom_reg;
    ptr_t    bottom_next;

    logic    pend_reg;
    logic    pend_next;
    status_t pend_status_reg;
    status_t pend_status_next;
    logic    pend_use_reg;
    logic    pend_use_next;
    logic    pend_done;

    logic    out_valid_reg;
    logic    out_valid_next;
    status_t out_status_reg;
    data_t   out_value_reg;

    logic    wr_en;
    logic    rd_en;
    addr_t   rd_addr;
    data_t   rd_data;

    assign in_op    = s_tdata[OP_W-1:0];
    assign in_value = s_tdata[OP_W+DATA_W-1:OP_W];

    assign s_tready = !pend_reg;
    assign s_fire   = s_tvalid && s_tready;

    assign level    = bottom_reg - top_reg;
    assign is_empty = (level == '0);
    assign is_full  = (level >= PTR_W'(DEPTH));
    assign newest   = bottom_reg - 1'b1;

    assign pend_done = pend_reg && (!out_valid_reg || m_tready);

    always_comb
    begin
        top_next         = top_reg;
        bottom_next      = bottom_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = top_reg[ADDR_W-1:0];
        pend_status_next = ST_OK;
        pend_use_next    = 1'b0;
        if (s_fire)
        begin
            unique case (in_op)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        bottom_next = bottom_reg + 1'b1;
                    end
                end
                OP_TAKE:
                begin
                    if (is_empty)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = newest[ADDR_W-1:0];
                        pend_use_next = 1'b1;
                        if (level == PTR_W'(1))
                        begin
                            top_next = top_reg + 1'b1;
                        end
                        else
                        begin
                            bottom_next = newest;
                        end
                    end
                end
                OP_STEAL:
                begin
                    if (is_empty)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        pend_use_next = 1'b1;
                        top_next      = top_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (s_fire)
        begin
            pend_next = 1'b1;
        end
        else if (pend_done)
        begin
            pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (pend_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            bottom_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            bottom_reg    <= bottom_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            pend_status_reg <= pend_status_next;
            pend_use_reg    <= pend_use_next;
        end
        if (pend_done)
        begin
            out_status_reg <= pend_status_reg;
            out_value_reg  <= pend_use_reg ? rd_data : '0;
        end
    end

    wsd_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (bottom_reg[ADDR_W-1:0]),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_value_reg, out_status_reg};

    // The fill level never exceeds the deque depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= PTR_W'(DEPTH))
    else $error("deque fill level above depth");

    // A push into a deque with room advances the bottom pointer by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && in_op == OP_PUSH && !is_full
        |=> bottom_reg == PTR_W'($past(bottom_reg) + 1'b1))
    else $error("push did not advance bottom pointer");

    // A take or steal on an empty deque leaves both pointers unchanged and records status empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && is_empty && (in_op == OP_TAKE || in_op == OP_STEAL)
        |=> $stable(top_reg) && $stable(bottom_reg) && pend_status_reg == ST_EMPTY)
    else $error("empty removal changed pointers or status");

    // A pending item with a free output register becomes a valid result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !out_valid_reg |=> out_valid_reg && !pend_reg)
    else $error("pending item not moved to output");

endmodule

`default_nettype wire

// ===== bench/work_stealing_deque_core_test.sv =====
// Self-checking testbench for the work-stealing deque core with a streaming driver and monitor.
`default_nettype none

module work_stealing_deque_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam op_t OP_RESERVED  = 2'd3;
    localparam int  RANDOM_ITEMS = 1900;
    localparam int  QUIET_LIMIT  = 1000;
    localparam int  HOLD_AT      = 600;
    localparam int  HOLD_CYCLES  = 90;

    // Predicts each result from its own copy of the deque and checks results in order.
    class deque_ledger;
        typedef struct {
            status_t status;
            data_t   value;
        } outcome_t;

        data_t    slots [DEPTH];
        ptr_t     top_ptr;
        ptr_t     bot_ptr;
        outcome_t owed [$];
        int       errors;

        function new();
            top_ptr = '0;
            bot_ptr = '0;
            errors  = 0;
        endfunction

        function void note_op(op_t op, data_t word);
            ptr_t     level;
            ptr_t     newest;
            outcome_t o;
            level    = ptr_t'(bot_ptr - top_ptr);
            o.status = ST_OK;
            o.value  = '0;
            case (op)
                OP_PUSH:
                begin
                    if (level >= DEPTH)
                    begin
                        o.status = ST_FULL;
                    end
                    else
                    begin
                        slots[bot_ptr[ADDR_W-1:0]] = word;
                        bot_ptr = ptr_t'(bot_ptr + 1'b1);
                    end
                end
                OP_TAKE:
                begin
                    if (level == 0)
                    begin
                        o.status = ST_EMPTY;
                    end
                    else
                    begin
                        newest  = ptr_t'(bot_ptr - 1'b1);
                        o.value = slots[newest[ADDR_W-1:0]];
                        // The last word leaves by the top pointer.
                        if (level == 1)
                            top_ptr = ptr_t'(top_ptr + 1'b1);
                        else
                            bot_ptr = newest;
                    end
                end
                OP_STEAL:
                begin
                    if (level == 0)
                    begin
                        o.status = ST_EMPTY;
                    end
                    else
                    begin
                        o.value = slots[top_ptr[ADDR_W-1:0]];
                        top_ptr = ptr_t'(top_ptr + 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
            owed.push_back(o);
        endfunction

        function void check_result(status_t status, data_t value);
            outcome_t o;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d value %h",
                         $time, status, value);
                errors++;
                return;
            end
            o = owed.pop_front();
            if (status !== o.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, o.status, status);
                errors++;
            end
            if (value !== o.value)
            begin
                $display("%0t: item_value mismatch, expected %h, actual %h",
                         $time, o.value, value);
                errors++;
            end
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    deque_ledger ledger = new();
    int          cyc    = 0;
    int          quiet  = 0;
    bit          calm_sender;

    work_stealing_deque_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        else if (r < 88)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(40, 20);
    endfunction

    function automatic data_t task_word();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        else if (r < 22)
            return data_t'(1) << $urandom_range(DATA_W - 1);
        else
            return $urandom;
    endfunction

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_op(op_t op, data_t word);
        int gap;
        gap = calm_sender ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_PAD_W{1'b0}}, word, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ledger.note_op(op, word);
    endtask

    task automatic run_directed();
        send_op(OP_TAKE, task_word());
        send_op(OP_STEAL, task_word());
        send_op(OP_PUSH, '0);
        send_op(OP_PUSH, '1);
        send_op(OP_TAKE, task_word());
        send_op(OP_TAKE, task_word());
        send_op(OP_STEAL, task_word());
        send_op(OP_RESERVED, task_word());
        for (int i = 0; i < DEPTH; i++)
            send_op(OP_PUSH, (i % 2 == 0) ? data_t'(1) << (2 * i) : ~(data_t'(1) << (2 * i)));
        send_op(OP_PUSH, '1);
        send_op(OP_STEAL, task_word());
        send_op(OP_TAKE, task_word());
    endtask

    // Phases favour pushes, favour removals or hold even, so the deque keeps filling and draining.
    task automatic run_random();
        int push_pct;
        int left;
        int r;
        op_t op;
        left = 0;
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (left == 0)
            begin
                left = $urandom_range(120, 30);
                r = $urandom_range(2);
                push_pct = (r == 0) ? 80 : (r == 1) ? 50 : 20;
                calm_sender = ($urandom_range(3) == 0);
            end
            left--;
            r = $urandom_range(99);
            if (r < 1)
                op = OP_RESERVED;
            else if (r < push_pct)
                op = OP_PUSH;
            else if ($urandom_range(1) == 0)
                op = OP_TAKE;
            else
                op = OP_STEAL;
            send_op(op, task_word());
        end
    endtask

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (rst_n && m_tvalid && m_tready)
            ledger.check_result(m_tdata[STATUS_W-1:0], m_tdata[STATUS_W +: DATA_W]);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("** work_stealing_deque_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int run;
        int stall;
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && cyc >= HOLD_AT)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            run = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = idle_len();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        calm_sender = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        while (ledger.owed.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (ledger.errors == 0)
            $display("** work_stealing_deque_core: PASSED **");
        else
            $display("** work_stealing_deque_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
